@@ rtl/fsgd_pkg.sv @@
// shared types, codes and reset values for the footswitch gesture decoder
// no dependencies
`default_nettype none

package fsgd_pkg;

    localparam int unsigned POS_W  = 2;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFGT_W = 16;
    localparam int unsigned MASK_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_MASK = 2'h3;
    localparam logic [POS_W-1:0] POS_NONE = 2'd0;
    localparam logic [POS_W-1:0] POS_TIP  = 2'd1;
    localparam logic [POS_W-1:0] POS_RING = 2'd2;
    localparam logic [POS_W-1:0] POS_BOTH = 2'd3;

    localparam logic [KIND_W-1:0] KIND_PRESS        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HOLD         = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOLD_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MASK = 2'd3;

    localparam logic [CFGT_W-1:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [CFGT_W-1:0] HOLD_TIME_RESET = 16'd500;
    localparam logic [MASK_W-1:0] HOLD_MASK_RESET = 3'd0;

    typedef struct packed {
        logic [POS_W-1:0]  last_raw;
        logic [POS_W-1:0]  debounced;
        logic [POS_W-1:0]  armed;
        logic [TIME_W-1:0] change_time;
        logic [TIME_W-1:0] start_time;
        logic              hold_done;
        logic [POS_W-1:0]  seen_open;
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  switch_index;
        logic [KIND_W-1:0] kind;
    } t_event;

    typedef struct packed {
        logic              enable;
        logic [CFGT_W-1:0] debounce;
        logic [CFGT_W-1:0] hold_time;
        logic [MASK_W-1:0] hold_mask;
    } t_cfg;

    localparam t_state STATE_CLEAR = '0;

    // hold-assigned bit for a nonzero position
    function automatic logic hold_assigned(input logic [MASK_W-1:0] mask,
                                           input logic [POS_W-1:0] pos);
        logic bit_v;
        unique case (pos)
            POS_TIP:  bit_v = mask[0];
            POS_RING: bit_v = mask[1];
            POS_BOTH: bit_v = mask[2];
            default:  bit_v = 1'b0;
        endcase
        return bit_v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fsgd_step.sv @@
// combinational update of the gesture state for one contact sample
// depends on fsgd_pkg
`default_nettype none

module fsgd_step (
    input  wire fsgd_pkg::t_cfg                     i_cfg,
    input  wire fsgd_pkg::t_state                   i_state,
    input  wire logic [fsgd_pkg::POS_W-1:0]  i_raw,
    input  wire logic [fsgd_pkg::TIME_W-1:0] i_now,
    output fsgd_pkg::t_state                        o_state,
    output fsgd_pkg::t_event                        o_event
);
    import fsgd_pkg::*;

    logic [POS_W-1:0]  seen;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] change_t;
    logic [TIME_W-1:0] dt_change;
    logic [TIME_W-1:0] dt_start;
    logic              settle;
    t_state            mid;

    always_comb begin
        seen     = i_state.seen_open | (~i_raw & POS_MASK);
        pos      = i_raw & seen;
        change_t = (pos != i_state.last_raw) ? i_now : i_state.change_time;
        // wrapping difference
        dt_change = i_now - change_t;
        settle = (dt_change >= {{(TIME_W-CFGT_W){1'b0}}, i_cfg.debounce})
                 && (pos != i_state.debounced);

        mid             = i_state;
        mid.seen_open   = seen;
        mid.last_raw    = pos;
        mid.change_time = change_t;
        o_event         = '0;

        if (settle) begin
            mid.debounced = pos;
            if (pos != POS_NONE) begin
                if (i_state.armed == POS_NONE) begin
                    mid.start_time = i_now;
                end
                // both wins, and escalation stops once a hold has fired
                if (!i_state.hold_done) begin
                    if (pos == POS_BOTH) begin
                        mid.armed = POS_BOTH;
                    end else if (i_state.armed != POS_BOTH) begin
                        mid.armed = pos;
                    end
                end
            end else if (i_state.armed != POS_NONE) begin
                o_event.valid        = 1'b1;
                o_event.switch_index = i_state.armed - POS_TIP;
                o_event.kind         = i_state.hold_done ? KIND_HOLD_RELEASE : KIND_PRESS;
                mid.armed            = POS_NONE;
                mid.hold_done        = 1'b0;
            end
        end

        dt_start = i_now - mid.start_time;
        o_state  = mid;
        if (!mid.hold_done && (mid.armed != POS_NONE)
            && (dt_start >= {{(TIME_W-CFGT_W){1'b0}}, i_cfg.hold_time})
            && hold_assigned(i_cfg.hold_mask, mid.armed)) begin
            o_state.hold_done    = 1'b1;
            o_event.valid        = 1'b1;
            o_event.switch_index = mid.armed - POS_TIP;
            o_event.kind         = KIND_HOLD;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fsgd_out_stage.sv @@
// result register holding one event beat until it is taken
// depends on fsgd_pkg
`default_nettype none

module fsgd_out_stage (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire fsgd_pkg::t_event             i_event,
    input  wire logic                         i_out_ready,
    output logic                              o_free,
    output logic                              o_out_valid,
    output logic [fsgd_pkg::POS_W-1:0]        o_switch_index,
    output logic [fsgd_pkg::KIND_W-1:0]       o_gesture_kind
);
    import fsgd_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [POS_W-1:0]  r_index;
    logic [KIND_W-1:0] r_kind;

    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid && !i_out_ready;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_index <= i_event.switch_index;
            r_kind  <= i_event.kind;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_switch_index = r_index;
    assign o_gesture_kind = r_kind;

endmodule

`default_nettype wire

@@ rtl/footswitch_gesture_decoder.sv @@
// footswitch gesture decoder: debounce, sticky armed position, hold and release events
// a sample is registered in the input register, then decoded into the result register that drives o_out_valid
// throughput: one sample per cycle but for the stall below; the single decode stage between the two registers sets it
// a sample that would raise an event waits only while the result register is still full
// reset (synchronous, active low) clears state and loads register defaults; enable writes clear state
// depends on fsgd_pkg, fsgd_step, fsgd_out_stage
`default_nettype none

module footswitch_gesture_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fsgd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fsgd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_tip_closed,
    input  wire logic                              i_ring_closed,
    input  wire logic [fsgd_pkg::TIME_W-1:0]       i_now_ms,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [fsgd_pkg::POS_W-1:0]             o_switch_index,
    output logic [fsgd_pkg::KIND_W-1:0]            o_gesture_kind
);
    import fsgd_pkg::*;

    t_cfg              r_cfg;
    t_state            r_state;
    t_state            step_state;
    t_event            step_event;
    logic              r_in_valid;
    logic              n_in_valid;
    logic [POS_W-1:0]  r_raw;
    logic [TIME_W-1:0] r_now;
    logic              out_free;
    logic              advance;
    logic              in_take;

    // a beat leaves the input register unless its event finds the result register full
    assign advance    = r_in_valid && (!r_cfg.enable || !step_event.valid || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid && !advance;
        if (in_take) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw <= {i_ring_closed, i_tip_closed};
            r_now <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.debounce  <= DEBOUNCE_RESET;
            r_cfg.hold_time <= HOLD_TIME_RESET;
            r_cfg.hold_mask <= HOLD_MASK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE:    r_cfg.enable    <= i_cfg_data[0];
                REG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data[CFGT_W-1:0];
                REG_HOLD_TIME: r_cfg.hold_time <= i_cfg_data[CFGT_W-1:0];
                REG_HOLD_MASK: r_cfg.hold_mask <= i_cfg_data[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (i_cfg_we && (i_cfg_index == REG_ENABLE)) begin
            r_state <= STATE_CLEAR;
        end else if (advance && r_cfg.enable) begin
            r_state <= step_state;
        end
    end

    fsgd_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_raw   (r_raw),
        .i_now   (r_now),
        .o_state (step_state),
        .o_event (step_event)
    );

    fsgd_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance && r_cfg.enable && step_event.valid),
        .i_event        (step_event),
        .i_out_ready    (i_out_ready),
        .o_free         (out_free),
        .o_out_valid    (o_out_valid),
        .o_switch_index (o_switch_index),
        .o_gesture_kind (o_gesture_kind)
    );

endmodule

`default_nettype wire

@@ tb/sv/footswitch_gesture_decoder_tb.sv @@
// self-checking testbench for footswitch_gesture_decoder: a scoreboard class predicts
// the gesture events of every accepted contact sample and checks each event beat
// depends on fsgd_pkg and the footswitch_gesture_decoder rtl
`timescale 1ns / 1ps

module footswitch_gesture_decoder_tb;
    import fsgd_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]  switch_index;
        logic [KIND_W-1:0] kind;
    } t_gesture_event;

    class gesture_scoreboard;
        logic              enable;
        logic [CFGT_W-1:0] debounce_ms;
        logic [CFGT_W-1:0] hold_ms;
        logic [MASK_W-1:0] hold_mask;

        logic [POS_W-1:0]  last_raw;
        logic [POS_W-1:0]  debounced;
        logic [POS_W-1:0]  armed;
        logic [POS_W-1:0]  seen_open;
        logic [TIME_W-1:0] change_at;
        logic [TIME_W-1:0] gesture_start;
        logic              hold_fired;

        t_gesture_event expected_q[$];
        int unsigned n_samples;
        int unsigned n_events;
        int unsigned n_errors;
        int unsigned n_settings;

        function new();
            enable      = 1'b0;
            debounce_ms = DEBOUNCE_RESET;
            hold_ms     = HOLD_TIME_RESET;
            hold_mask   = HOLD_MASK_RESET;
            n_samples   = 0;
            n_events    = 0;
            n_errors    = 0;
            n_settings  = 0;
            clear_state();
        endfunction

        function void clear_state();
            last_raw      = POS_NONE;
            debounced     = POS_NONE;
            armed         = POS_NONE;
            seen_open     = POS_NONE;
            change_at     = '0;
            gesture_start = '0;
            hold_fired    = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_ENABLE: begin
                    enable = data[0];
                    clear_state();
                    n_settings++;
                end
                REG_DEBOUNCE:  debounce_ms = data[CFGT_W-1:0];
                REG_HOLD_TIME: hold_ms = data[CFGT_W-1:0];
                REG_HOLD_MASK: hold_mask = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function void queue_event(logic [POS_W-1:0] pos, logic [KIND_W-1:0] kind);
            t_gesture_event ev;
            ev.switch_index = pos - 2'd1;
            ev.kind         = kind;
            expected_q.push_back(ev);
        endfunction

        // contacts: bit 0 tip, bit 1 ring
        function void note_sample(logic [POS_W-1:0] contacts, logic [TIME_W-1:0] now);
            logic [POS_W-1:0]  raw;
            logic [TIME_W-1:0] stable_for;
            logic [TIME_W-1:0] held_for;
            n_samples++;
            if (!enable) return;
            raw = contacts;
            // a contact stays masked until it has been seen open once
            seen_open |= ~raw;
            raw &= seen_open;
            if (raw != last_raw) begin
                last_raw  = raw;
                change_at = now;
            end
            stable_for = now - change_at;
            if (stable_for >= debounce_ms && raw != debounced) begin
                debounced = raw;
                if (raw != POS_NONE) begin
                    if (armed == POS_NONE) gesture_start = now;
                    // both wins, and the armed position stays once a hold has fired
                    if (!hold_fired) begin
                        if (raw == POS_BOTH) armed = POS_BOTH;
                        else if (armed != POS_BOTH) armed = raw;
                    end
                end else if (armed != POS_NONE) begin
                    queue_event(armed, hold_fired ? KIND_HOLD_RELEASE : KIND_PRESS);
                    armed      = POS_NONE;
                    hold_fired = 1'b0;
                end
            end
            held_for = now - gesture_start;
            if (!hold_fired && armed != POS_NONE && held_for >= hold_ms
                    && hold_mask[armed - 2'd1]) begin
                hold_fired = 1'b1;
                queue_event(armed, KIND_HOLD);
            end
        endfunction

        function void check_event(logic [POS_W-1:0] switch_index, logic [KIND_W-1:0] kind);
            t_gesture_event want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected event switch_index %0d gesture_kind %0d, none expected",
                         $time, switch_index, kind);
                n_errors++;
                return;
            end
            want = expected_q.pop_front();
            n_events++;
            if (want.switch_index !== switch_index) begin
                $display("%0t: switch_index mismatch: expected %0d, actual %0d",
                         $time, want.switch_index, switch_index);
                n_errors++;
            end
            if (want.kind !== kind) begin
                $display("%0t: gesture_kind mismatch: expected %0d, actual %0d",
                         $time, want.kind, kind);
                n_errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_tip_closed;
    logic                  i_ring_closed;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [POS_W-1:0]      o_switch_index;
    logic [KIND_W-1:0]     o_gesture_kind;

    gesture_scoreboard sb;
    logic [TIME_W-1:0] sim_ms;
    int unsigned       step_max;
    bit                tx_burst;
    bit                rx_burst;
    bit                rx_hold;

    footswitch_gesture_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_tip_closed   (i_tip_closed),
        .i_ring_closed  (i_ring_closed),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_switch_index (o_switch_index),
        .o_gesture_kind (o_gesture_kind)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // event beats are checked before the sample beat of the same edge is predicted
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_out_valid && i_out_ready) sb.check_event(o_switch_index, o_gesture_kind);
            if (i_in_valid && o_in_ready) sb.note_sample({i_ring_closed, i_tip_closed}, i_now_ms);
        end
    end

    task automatic send_sample(input logic [POS_W-1:0] contacts, input logic [TIME_W-1:0] now);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_tip_closed  <= contacts[0];
        i_ring_closed <= contacts[1];
        i_now_ms      <= now;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic advance(input logic [POS_W-1:0] pos, input int unsigned dt);
        sim_ms += dt;
        send_sample(pos, sim_ms);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        sb.write_reg(index, data);
        @(negedge i_clk);
    endtask

    // enable goes last since its write clears the decoder state
    task automatic apply_settings(input logic en, input logic [CFGT_W-1:0] deb,
                                  input logic [CFGT_W-1:0] hold, input logic [MASK_W-1:0] mask);
        cfg_write(REG_DEBOUNCE, deb);
        cfg_write(REG_HOLD_TIME, hold);
        cfg_write(REG_HOLD_MASK, CFG_DATA_W'(mask));
        cfg_write(REG_ENABLE, CFG_DATA_W'(en));
        i_cfg_we <= 1'b0;
        step_max = (32'(deb) + 32'(hold)) / 6 + 1;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // bounce in, hold a position for a random time, maybe escalate, bounce out, rest open
    task automatic play_gesture();
        logic [POS_W-1:0]  pos;
        int unsigned       deb;
        int unsigned       hold;
        int unsigned       dt;
        longint unsigned   target;
        longint unsigned   held;
        deb  = sb.debounce_ms;
        hold = sb.hold_ms;
        pos  = 2'($urandom_range(1, 3));
        repeat ($urandom_range(0, 3)) advance(2'($urandom_range(0, 3)), $urandom_range(0, deb / 3));
        target = $urandom_range(0, deb + hold + hold / 2 + 1);
        held   = 0;
        while (held <= target) begin
            if (pos != POS_BOTH && $urandom_range(0, 15) == 0) pos = POS_BOTH;
            dt = $urandom_range(1, step_max);
            held += dt;
            advance(pos, dt);
        end
        repeat ($urandom_range(0, 3)) advance(2'($urandom_range(0, 3)), $urandom_range(0, deb / 3));
        target = deb + $urandom_range(0, step_max);
        held   = 0;
        while (held <= target) begin
            dt = $urandom_range(1, step_max);
            held += dt;
            advance(POS_NONE, dt);
        end
    endtask

    task automatic play_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) == 0) sim_ms = $urandom();
            advance(2'($urandom_range(0, 3)), $urandom_range(0, step_max));
        end
    endtask

    initial begin
        int unsigned       phase_end;
        logic              en;
        logic [CFGT_W-1:0] deb;
        logic [CFGT_W-1:0] hold;
        logic [MASK_W-1:0] mask;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_ENABLE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_tip_closed  = 1'b0;
        i_ring_closed = 1'b0;
        i_now_ms      = '0;
        sim_ms        = '0;
        step_max      = 1;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // disabled out of reset: samples are ignored
        send_sample(POS_BOTH, 32'd10);
        send_sample(POS_TIP, 32'd40);
        drain();

        // reset timings, no hold assigned; contacts start closed and stay masked
        cfg_write(REG_ENABLE, 16'd1);
        i_cfg_we <= 1'b0;
        send_sample(POS_BOTH, 32'd1000);
        send_sample(POS_BOTH, 32'd1003);
        send_sample(POS_TIP, 32'd1005);
        send_sample(POS_NONE, 32'd1008);
        send_sample(POS_TIP, 32'd1010);
        send_sample(POS_TIP, 32'd1030);
        send_sample(POS_TIP, 32'd1600);
        send_sample(POS_NONE, 32'd1610);
        send_sample(POS_NONE, 32'd1630);
        drain();

        // zero times act on the same sample; escalation blocked after a hold; time wraps
        apply_settings(1'b1, 16'd0, 16'd0, 3'b111);
        send_sample(POS_NONE, 32'hFFFF_FFF0);
        send_sample(POS_RING, 32'hFFFF_FFF1);
        send_sample(POS_BOTH, 32'hFFFF_FFF2);
        send_sample(POS_NONE, 32'hFFFF_FFF3);
        send_sample(POS_TIP, 32'd5);
        send_sample(POS_NONE, 32'd6);
        drain();

        // largest times, escalation to both before the hold fires
        apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 3'b100);
        send_sample(POS_NONE, 32'hFFFF_0000);
        send_sample(POS_TIP, 32'hFFFF_0001);
        send_sample(POS_TIP, 32'd0);
        send_sample(POS_BOTH, 32'd1);
        send_sample(POS_BOTH, 32'd65536);
        send_sample(POS_NONE, 32'd65537);
        send_sample(POS_NONE, 32'd131072);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    deb  = 16'd0;
                    hold = 16'd0;
                    mask = 3'($urandom_range(1, 7));
                end
                1: begin
                    deb  = 16'hFFFF;
                    hold = 16'hFFFF;
                    mask = 3'b111;
                end
                2: begin
                    deb  = 16'd2;
                    hold = 16'd30;
                    mask = 3'b000;
                end
                default: begin
                    deb  = 16'($urandom_range(0, 25));
                    hold = 16'($urandom_range(0, 150));
                    mask = 3'($urandom_range(0, 7));
                end
            endcase
            en = (ph != 3);
            apply_settings(en, deb, hold, mask);
            tx_burst = (ph == 0) || ($urandom_range(0, 3) == 0);
            rx_burst = (ph == 4) || ($urandom_range(0, 3) == 0);
            sim_ms   = $urandom();
            if (!en) begin
                repeat (4) play_noise();
            end else begin
                phase_end = sb.n_samples + 150;
                while (sb.n_samples < phase_end) begin
                    if ($urandom_range(0, 4) == 0) play_noise();
                    else play_gesture();
                end
            end
            drain();
        end

        $display("%0d samples over %0d settings, %0d gesture events checked, %0d mismatches",
                 sb.n_samples, sb.n_settings, sb.n_events, sb.n_errors);
        $display("covered masked contacts, zero and full-scale times, escalation, wrap, stalls");
        if (sb.n_errors == 0) begin
            $display("** footswitch_gesture_decoder: PASSED **");
        end else begin
            $display("** footswitch_gesture_decoder: FAILED **");
        end
        $finish;
    end

    // event side: random stalls per beat, or held off while rx_hold is set
    initial begin
        int unsigned stall;
        bit          got;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                i_out_ready <= 1'b0;
                @(negedge i_clk);
            end
            got = 1'b0;
            while (!got) begin
                if (rx_hold) begin
                    i_out_ready <= 1'b0;
                    @(negedge i_clk);
                end else begin
                    i_out_ready <= 1'b1;
                    @(posedge i_clk);
                    got = o_out_valid;
                    @(negedge i_clk);
                end
            end
        end
    end

    // long back-pressure stretch mid-run so the result register fills and input stalls
    initial begin
        rx_hold = 1'b0;
        @(posedge i_clk);
        while (sb.n_samples < 600) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d events outstanding", $time, sb.expected_q.size());
        $display("** footswitch_gesture_decoder: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/fsgd_pkg.sv
rtl/fsgd_step.sv
rtl/fsgd_out_stage.sv
rtl/footswitch_gesture_decoder.sv
tb/sv/footswitch_gesture_decoder_tb.sv
